@@ rtl/line_command_address_parser_macros.svh @@
// Assertion macros shared by the RTL of the line command address parser.
// Both macros sample on the rising edge of clk_i.
`ifndef LINE_COMMAND_ADDRESS_PARSER_MACROS_SVH
`define LINE_COMMAND_ADDRESS_PARSER_MACROS_SVH

// Checked only while the block is out of reset.
`define LCAP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, during reset as well.
`define LCAP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/lcap_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcap_pkg
// Constants and types of the line command address parser.
// ----------------------------------------------------------------------------
package lcap_pkg;

  localparam int unsigned LINE_LEN = 24;
  localparam int unsigned HEAD_LEN = 6;
  localparam int unsigned IDX_W    = $clog2(LINE_LEN);
  localparam int unsigned OCTETS   = 4;

  // Result item: two flags and eight octets, padded to whole bytes.
  localparam int unsigned OUT_BITS = 2 + 2 * OCTETS * 8;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_SEMI = 8'd59;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_ONE  = 8'd49;
  localparam logic [7:0] CHAR_G    = 8'd71;
  localparam logic [7:0] CHAR_E    = 8'd69;
  localparam logic [7:0] CHAR_T    = 8'd84;
  localparam logic [7:0] CHAR_A    = 8'd65;
  localparam logic [7:0] CHAR_M    = 8'd77;
  localparam logic [7:0] CHAR_I    = 8'd73;
  localparam logic [7:0] CHAR_P    = 8'd80;
  localparam logic [7:0] CHAR_W    = 8'd87;

  localparam logic [7:0] MUL_HUNDRED = 8'd100;
  localparam logic [7:0] MUL_TEN     = 8'd10;

  typedef logic [7:0]       byte_t;
  typedef logic [IDX_W-1:0] index_t;
  typedef byte_t            octets_t [OCTETS];

endpackage

`default_nettype wire

@@ rtl/line_command_address_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_command_address_parser
// Collects serial bytes into a line head, decodes each line on carriage
// return into request flags and IP / gateway address octets.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (low bit first)                        Items
//  s_axis    in   tdata[7:0] rx_byte                            one per byte
//  m_axis    out  tdata get_request, usb_request, ip_octet_a..d,
//                 gw_octet_a..d, zero pad to 72 bits            one per CR
//
//  An item is registered in the input register on acceptance and processed
//  from there; a carriage return writes its result into the result register.
//  One item per cycle is accepted, limited only by the single result
//  register when results are not taken.
//  Reset clears the line head, the write index and all octets to zero.
//  A stalled result holds the input stage only when it is a carriage return.
// ----------------------------------------------------------------------------
module line_command_address_parser (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: rx_byte[7:0]
  input  wire  [7:0]                    s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  // tdata: get_request[0], usb_request[1], ip_octet_a[9:2] .. ip_octet_d[33:26],
  //        gw_octet_a[41:34] .. gw_octet_d[65:58], zero pad [71:66]
  output logic [lcap_pkg::OUT_W-1:0]    m_axis_tdata_o
);
  import lcap_pkg::*;

  `include "line_command_address_parser_macros.svh"

  // Input register.
  logic  in_valid_q;
  byte_t in_byte_q;

  // Parser state.
  byte_t   head_q [HEAD_LEN];
  byte_t   head_d [HEAD_LEN];
  index_t  idx_q, idx_d;
  octets_t ip_q, ip_d;
  octets_t gw_q, gw_d;

  // Result register.
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  logic          is_cr;
  logic          advance;
  logic          get_req, usb_req;
  byte_t         sel;
  logic          sel_ok;
  logic [IDX_W:0] idx_inc;

  function automatic byte_t decode_octet(byte_t old, byte_t p3, byte_t p4, byte_t p5);
    byte_t v;
    byte_t d3;
    byte_t d4;
    byte_t d5;
    d3 = p3 - CHAR_ZERO;
    d4 = p4 - CHAR_ZERO;
    d5 = p5 - CHAR_ZERO;
    v  = old;
    if (p3 != CHAR_SEMI) v = 8'(d3 * MUL_HUNDRED);
    if (p4 != CHAR_SEMI) v = 8'(v + 8'(d4 * MUL_TEN));
    if (p5 != CHAR_SEMI) v = 8'(v + d5);
    return v;
  endfunction

  assign is_cr   = (in_byte_q == CHAR_CR);
  // A non-return byte needs no result slot and always moves on.
  assign advance = in_valid_q && (!is_cr || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    idx_inc = {1'b0, idx_q} + (IDX_W+1)'(1);
    ip_d    = ip_q;
    gw_d    = gw_q;
    for (int k = 0; k < HEAD_LEN; k++) begin
      head_d[k] = head_q[k];
      if (idx_q == IDX_W'(k)) begin
        head_d[k] = in_byte_q;
      end
    end
    if (is_cr) begin
      idx_d = '0;
    end else if (idx_inc >= (IDX_W+1)'(LINE_LEN)) begin
      idx_d = '0;
    end else begin
      idx_d = idx_inc[IDX_W-1:0];
    end

    // Decode sees the line head with the carriage return already written.
    get_req = (head_d[0] == CHAR_G) && (head_d[1] == CHAR_E) && (head_d[2] == CHAR_T);
    usb_req = (head_d[0] == CHAR_A) && (head_d[1] == CHAR_M) && (head_d[2] == CHAR_ONE);
    sel     = head_d[2] - CHAR_ONE;
    sel_ok  = (sel < 8'd4);
    if (is_cr && sel_ok) begin
      if (head_d[0] == CHAR_I && head_d[1] == CHAR_P) begin
        ip_d[sel[1:0]] = decode_octet(ip_q[sel[1:0]], head_d[3], head_d[4], head_d[5]);
      end
      if (head_d[0] == CHAR_G && head_d[1] == CHAR_W) begin
        gw_d[sel[1:0]] = decode_octet(gw_q[sel[1:0]], head_d[3], head_d[4], head_d[5]);
      end
    end

    out_data_d = {(OUT_W-OUT_BITS)'(0),
                  gw_d[3], gw_d[2], gw_d[1], gw_d[0],
                  ip_d[3], ip_d[2], ip_d[1], ip_d[0],
                  usb_req, get_req};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      for (int k = 0; k < HEAD_LEN; k++) begin
        head_q[k] <= '0;
      end
      for (int k = 0; k < OCTETS; k++) begin
        ip_q[k] <= '0;
        gw_q[k] <= '0;
      end
    end else if (advance) begin
      idx_q  <= idx_d;
      head_q <= head_d;
      ip_q   <= ip_d;
      gw_q   <= gw_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_cr) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_cr) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `LCAP_ASSERT_ALWAYS(a_idx_range, idx_q < IDX_W'(LINE_LEN), "write index beyond line length")
  `LCAP_ASSERT(a_cr_gives_result, advance && is_cr |=> out_valid_q, "carriage return lost its result")
  `LCAP_ASSERT(a_hold_input, in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q), "stalled item dropped")
  `LCAP_ASSERT(a_idx_after_cr, advance && is_cr |=> idx_q == '0, "index not cleared after line end")

endmodule

`default_nettype wire

@@ bench/tb_line_command_address_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_command_address_parser
// Feeds serial bytes into the parser and checks the result item of every
// line against a predictor kept in the bench. A short directed part is
// followed by random, mostly well-formed command lines with random digits,
// bad selectors, short and wrapped long lines, and noise. The sender works
// in bursts with gaps, and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_line_command_address_parser;
  import lcap_pkg::*;

  localparam int unsigned IP_LSB     = 2;
  localparam int unsigned GW_LSB     = 2 + OCTETS * 8;
  localparam int unsigned BYTE_COUNT = 1100;

  typedef enum int unsigned {
    CMD_GET, CMD_USB, CMD_IP, CMD_GW, CMD_SHORT, CMD_LONG, CMD_NOISE
  } line_kind_e;

  typedef struct packed {
    logic              get_req;
    logic              usb_req;
    logic [OCTETS-1:0][7:0] ip;
    logic [OCTETS-1:0][7:0] gw;
  } line_result_t;

  // Tracks the line head and the address octets, and holds the result
  // expected for every line whose carriage return has been accepted.
  class address_tracker;
    byte_t                  head [HEAD_LEN];
    int unsigned            wr_pos;
    logic [OCTETS-1:0][7:0] ip_addr;
    logic [OCTETS-1:0][7:0] gw_addr;
    line_result_t           lines_due [$];
    int unsigned            errors;

    function new();
      foreach (head[k]) head[k] = '0;
      wr_pos  = 0;
      ip_addr = '0;
      gw_addr = '0;
      errors  = 0;
    endfunction

    // Semicolons skip a digit position; nothing checks that a digit is one.
    function byte_t decode_octet(byte_t old);
      byte_t v;
      v = old;
      if (head[3] != CHAR_SEMI) v = 8'((head[3] - CHAR_ZERO) * MUL_HUNDRED);
      if (head[4] != CHAR_SEMI) v = 8'(v + (head[4] - CHAR_ZERO) * MUL_TEN);
      if (head[5] != CHAR_SEMI) v = 8'(v + (head[5] - CHAR_ZERO));
      return v;
    endfunction

    function void note_byte(byte_t b);
      line_result_t r;
      byte_t        sel;
      if (b != CHAR_CR) begin
        if (wr_pos < HEAD_LEN) head[wr_pos] = b;
        wr_pos++;
        if (wr_pos >= LINE_LEN) wr_pos = 0;
        return;
      end
      if (wr_pos < HEAD_LEN) head[wr_pos] = CHAR_CR;
      wr_pos = 0;
      r.get_req = (head[0] == CHAR_G && head[1] == CHAR_E && head[2] == CHAR_T);
      r.usb_req = (head[0] == CHAR_A && head[1] == CHAR_M && head[2] == CHAR_ONE);
      sel = head[2] - CHAR_ONE;
      if (sel < OCTETS) begin
        if (head[0] == CHAR_I && head[1] == CHAR_P) ip_addr[sel] = decode_octet(ip_addr[sel]);
        if (head[0] == CHAR_G && head[1] == CHAR_W) gw_addr[sel] = decode_octet(gw_addr[sel]);
      end
      r.ip = ip_addr;
      r.gw = gw_addr;
      lines_due.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [OUT_W-1:0] d);
      line_result_t e;
      if (lines_due.size() == 0) begin
        report("result item with no line pending");
        return;
      end
      e = lines_due.pop_front();
      if (d[0] !== e.get_req) report($sformatf("get_request %b, expected %b", d[0], e.get_req));
      if (d[1] !== e.usb_req) report($sformatf("usb_request %b, expected %b", d[1], e.usb_req));
      for (int k = 0; k < OCTETS; k++) begin
        if (d[IP_LSB + 8 * k +: 8] !== e.ip[k])
          report($sformatf("ip octet %0d is %0d, expected %0d", k, d[IP_LSB + 8 * k +: 8],
                           e.ip[k]));
        if (d[GW_LSB + 8 * k +: 8] !== e.gw[k])
          report($sformatf("gw octet %0d is %0d, expected %0d", k, d[GW_LSB + 8 * k +: 8],
                           e.gw[k]));
      end
      if (d[OUT_W-1:OUT_BITS] !== '0) report("padding bits of result item not zero");
    endtask
  endclass

  logic             clk     = 1'b0;
  logic             rst_n   = 1'b1;
  logic             s_valid = 1'b0;
  byte_t            s_data  = '0;
  logic             m_ready = 1'b0;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [OUT_W-1:0] m_axis_tdata_o;

  address_tracker tracker = new();

  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned rx_mode    = 0;
  int unsigned rx_left    = 0;
  int unsigned rx_phase   = 0;

  line_command_address_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check accepted items, then pick the next ready value from
  // a stall pattern that is chosen anew at random.
  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid_o && m_ready) tracker.check_result(m_axis_tdata_o);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(5, 60);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= $urandom_range(0, 1);
      2: m_ready <= (rx_phase % 5 == 0);
      default: m_ready <= (rx_phase % 7 != 3);
    endcase
  end

  function automatic byte_t any_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Any byte except a carriage return, so the line keeps going.
  function automatic byte_t text_byte();
    byte_t b;
    b = any_byte();
    return (b == CHAR_CR) ? CHAR_SEMI : b;
  endfunction

  function automatic byte_t octet_char();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return byte_t'(CHAR_ZERO + $urandom_range(0, 9));
    if (r < 17) return CHAR_SEMI;
    return any_byte();
  endfunction

  task automatic send_byte(input byte_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk);
    while (!s_axis_tready_o) @(posedge clk);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(byte_t'(s[i]));
  endtask

  // One line of the given kind, ended by a carriage return. A long line wraps
  // the buffer and then carries a real command, at its start only on an exact wrap.
  task automatic send_command(input line_kind_e kind);
    int unsigned n;
    if (kind == CMD_NOISE) begin
      send_byte(any_byte());
      return;
    end
    if (kind == CMD_LONG) begin
      n = $urandom_range(0, 1) ? LINE_LEN : LINE_LEN + $urandom_range(1, 10);
      repeat (n) send_byte(text_byte());
      kind = line_kind_e'($urandom_range(CMD_GET, CMD_GW));
    end
    case (kind)
      CMD_GET: send_text("GET");
      CMD_USB: send_text("AM1");
      CMD_IP, CMD_GW: begin
        if (kind == CMD_IP) send_text("IP");
        else send_text("GW");
        send_byte(($urandom_range(0, 7) == 0) ? any_byte()
                                               : byte_t'(CHAR_ONE + $urandom_range(0, 3)));
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : 3;
        repeat (n) send_byte(octet_char());
      end
      default: repeat ($urandom_range(0, 5)) send_byte(text_byte());
    endcase
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_byte(text_byte());
    send_byte(CHAR_CR);
  endtask

  initial begin
    int unsigned r;
    // The falling edge comes after every process waits, so the block sees it.
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines: both requests, a skipped hundreds digit with a
    // non-digit in the ones place, a wrapping value, and the byte extremes.
    send_text("GET");
    send_byte(CHAR_CR);
    send_text("AM1");
    send_byte(CHAR_CR);
    send_text("IP4;9");
    send_byte(CHAR_CR);
    send_text("GW1999");
    send_byte(CHAR_CR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_CR);

    while (bytes_sent < BYTE_COUNT) begin
      r = $urandom_range(0, 99);
      if (r < 15)      send_command(CMD_GET);
      else if (r < 25) send_command(CMD_USB);
      else if (r < 50) send_command(CMD_IP);
      else if (r < 75) send_command(CMD_GW);
      else if (r < 85) send_command(CMD_SHORT);
      else if (r < 93) send_command(CMD_LONG);
      else             send_command(CMD_NOISE);
    end
    s_valid <= 1'b0;

    while (tracker.lines_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
